@@ sv/bole_pkg.sv @@
// Shared types and constants for the bounded ordered list engine.
// Holds the request/response structs and the command and status codes.
// No dependencies.
package bole_pkg;

   localparam int DEPTH      = 64;
   localparam int WORD_WIDTH = 32;
   localparam int VAL_W      = 32;
   localparam int POS_W      = 8;
   localparam int LEN_W      = 7;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_END   = 3'd1,
      CMD_INS_POS   = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_END   = 3'd4,
      CMD_DEL_POS   = 3'd5,
      CMD_SEARCH    = 3'd6,
      CMD_DUMP      = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_POS   = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_FULL      = 3'd3,
      ST_FOUND     = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic signed [VAL_W-1:0]  value;
      logic        [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [VAL_W-1:0]  item_value;
      logic        [LEN_W-1:0]  place;
      logic        [LEN_W-1:0]  length;
      logic                     last;
   } rsp_type;

endpackage

@@ sv/bole_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the list storage. No dependencies.
module bole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bounded_ordered_list_engine.sv @@
// Top level of the bounded ordered list engine: sequencer and list storage.
// Depends on bole_pkg and bole_ram.
//
// Usage:
//   A request (req_item: cmd, value, position) is taken at a rising edge with
//   start high and busy low. Commands insert at front, end or a 1-based
//   position, delete at front, end or a position, search for a value, or
//   dump the list front first.
//   Results appear on rsp_item for exactly one cycle with rsp_strobe high;
//   the receiver cannot stall them. Every command but dump gives one result
//   carrying the new length; dump gives one result per element, the final
//   one with last set, or one empty result.
//   Rejected commands, insert at end and delete at end answer in the cycle
//   after the request. Shifting inserts move entries in S_SHIFT_UP and then
//   write the new value in S_PUT; shifting deletes move entries in
//   S_SHIFT_DN; search examines one entry at a time in S_SEARCH; dump
//   streams one element per cycle. Entry moves are set by the one read and
//   one write port of the storage RAM that all entry moves go through.
//   busy is low again in the cycle the final result is shown, so the next
//   request can be taken then.
//   Reset empties the list and returns the sequencer to idle; the storage
//   itself is not cleared (only entries below the length are ever read).
module bounded_ordered_list_engine
   import bole_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SHIFT_UP = 6'b000010,
      S_PUT      = 6'b000100,
      S_SHIFT_DN = 6'b001000,
      S_SEARCH   = 6'b010000,
      S_DUMP     = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      key_ff, key_in;
   logic [VAL_W-1:0]      value_ff, value_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [WORD_WIDTH-1:0] mem_wdata;
   logic [IDX_W-1:0]      mem_raddr;
   logic [WORD_WIDTH-1:0] mem_rdata;

   logic [WORD_WIDTH-1:0] req_word;
   logic [WORD_WIDTH-1:0] held_word;
   logic [CMP_W-1:0]      pos_x;
   logic [CMP_W-1:0]      cnt_x;
   logic                  full;
   logic                  empty;
   logic [IDX_W-1:0]      key;

   function automatic rsp_type status_rsp(status_type s, logic [VAL_W-1:0] v,
                                          logic [LEN_W-1:0] pl, logic [LEN_W-1:0] len);
      rsp_type r;
      r.status     = s;
      r.item_value = v;
      r.place      = pl;
      r.length     = len;
      r.last       = 1'b1;
      return r;
   endfunction

   bole_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_word  = WORD_WIDTH'(req_item.value);
   assign held_word = WORD_WIDTH'($signed(value_ff));
   assign pos_x     = CMP_W'(req_item.position);
   assign cnt_x     = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = mem_rdata;
      mem_raddr     = '0;
      key           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in = req_item.value;
               unique case (req_item.cmd)
                  CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS: begin
                     unique case (req_item.cmd)
                        CMD_INS_FRONT: key = '0;
                        CMD_INS_END:   key = IDX_W'(count_ff);
                        default:       key = IDX_W'(pos_x - CMP_W'(1));
                     endcase
                     rsp_strobe_in = 1'b1;
                     if (req_item.cmd == CMD_INS_POS &&
                         (pos_x == '0 || pos_x > cnt_x + CMP_W'(1))) begin
                        rsp_in = status_rsp(ST_BAD_POS, req_item.value, '0,
                                            LEN_W'(count_ff));
                     end else if (full) begin
                        rsp_in = status_rsp(ST_FULL, req_item.value, '0,
                                            LEN_W'(count_ff));
                     end else if (CNT_W'(key) == count_ff) begin
                        mem_we    = 1'b1;
                        mem_waddr = key;
                        mem_wdata = req_word;
                        count_in  = count_ff + CNT_W'(1);
                        rsp_in    = status_rsp(ST_OK, req_item.value, '0,
                                               LEN_W'(count_ff + CNT_W'(1)));
                     end else begin
                        // make room: move entries up from the tail
                        rsp_strobe_in = 1'b0;
                        mem_raddr     = IDX_W'(count_ff - CNT_W'(1));
                        idx_in        = IDX_W'(count_ff);
                        key_in        = key;
                        state_in      = S_SHIFT_UP;
                     end
                  end
                  CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS: begin
                     unique case (req_item.cmd)
                        CMD_DEL_FRONT: key = '0;
                        CMD_DEL_END:   key = IDX_W'(count_ff - CNT_W'(1));
                        default:       key = IDX_W'(pos_x - CMP_W'(1));
                     endcase
                     rsp_strobe_in = 1'b1;
                     if (req_item.cmd == CMD_DEL_POS &&
                         (pos_x == '0 || pos_x > cnt_x)) begin
                        rsp_in = status_rsp(ST_BAD_POS, req_item.value, '0,
                                            LEN_W'(count_ff));
                     end else if (empty) begin
                        rsp_in = status_rsp(ST_EMPTY, req_item.value, '0,
                                            LEN_W'(count_ff));
                     end else if (CNT_W'(key) + CNT_W'(1) == count_ff) begin
                        count_in = count_ff - CNT_W'(1);
                        rsp_in   = status_rsp(ST_OK, req_item.value, '0,
                                              LEN_W'(count_ff - CNT_W'(1)));
                     end else begin
                        // close the gap: move entries down toward the front
                        rsp_strobe_in = 1'b0;
                        mem_raddr     = key + IDX_W'(1);
                        idx_in        = key;
                        state_in      = S_SHIFT_DN;
                     end
                  end
                  CMD_SEARCH: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = status_rsp(ST_EMPTY, req_item.value, '0, '0);
                     end else begin
                        mem_raddr = '0;
                        idx_in    = '0;
                        state_in  = S_SEARCH;
                     end
                  end
                  CMD_DUMP: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = status_rsp(ST_EMPTY, '0, '0, '0);
                     end else begin
                        mem_raddr = '0;
                        idx_in    = '0;
                        state_in  = S_DUMP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SHIFT_UP: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = mem_rdata;
            if (CNT_W'(idx_ff) == CNT_W'(key_ff) + CNT_W'(1)) begin
               state_in = S_PUT;
            end else begin
               mem_raddr = idx_ff - IDX_W'(2);
               idx_in    = idx_ff - IDX_W'(1);
            end
         end
         S_PUT: begin
            mem_we        = 1'b1;
            mem_waddr     = key_ff;
            mem_wdata     = held_word;
            count_in      = count_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_in        = status_rsp(ST_OK, value_ff, '0,
                                       LEN_W'(count_ff + CNT_W'(1)));
            state_in      = S_IDLE;
         end
         S_SHIFT_DN: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = mem_rdata;
            if (CNT_W'(idx_ff) + CNT_W'(2) == count_ff) begin
               count_in      = count_ff - CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_in        = status_rsp(ST_OK, value_ff, '0,
                                          LEN_W'(count_ff - CNT_W'(1)));
               state_in      = S_IDLE;
            end else begin
               mem_raddr = idx_ff + IDX_W'(2);
               idx_in    = idx_ff + IDX_W'(1);
            end
         end
         S_SEARCH: begin
            if (mem_rdata == held_word) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = status_rsp(ST_FOUND, value_ff,
                                          LEN_W'(CNT_W'(idx_ff) + CNT_W'(1)),
                                          LEN_W'(count_ff));
               state_in      = S_IDLE;
            end else if (CNT_W'(idx_ff) + CNT_W'(1) == count_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = status_rsp(ST_NOT_FOUND, value_ff, '0,
                                          LEN_W'(count_ff));
               state_in      = S_IDLE;
            end else begin
               mem_raddr = idx_ff + IDX_W'(1);
               idx_in    = idx_ff + IDX_W'(1);
            end
         end
         S_DUMP: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.status     = ST_OK;
            rsp_in.item_value = VAL_W'(mem_rdata);
            rsp_in.place      = LEN_W'(CNT_W'(idx_ff) + CNT_W'(1));
            rsp_in.length     = LEN_W'(count_ff);
            rsp_in.last       = (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);
            if (rsp_in.last) begin
               state_in = S_IDLE;
            end else begin
               mem_raddr = idx_ff + IDX_W'(1);
               idx_in    = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      key_ff   <= key_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
